@@ design/index_coordinate_selector_unit_defines.svh @@
// assertion macros shared by the index coordinate selector rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef INDEX_COORDINATE_SELECTOR_UNIT_DEFINES_SVH
`define INDEX_COORDINATE_SELECTOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ICS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ics assertion failed");
`define ICS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ics assertion failed");
`else
`define ICS_ASSERT(lbl, prop)
`define ICS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ design/ics_pkg.sv @@
// types and constants of the index coordinate selector
// depends on nothing; used by ics_table and the top level
package ics_pkg;
  localparam int CC_W    = 9;
  localparam int OT_W    = 10;
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 10;
  localparam int PAIR_W  = 17;
  localparam int SCORE_W = 27;
  localparam int COORD_W = 8;
  localparam int PROD_W  = PAIR_W + OT_W + 1;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [PAIR_W-1:0]  PAIR_MAX  = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTEGER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_APPLY   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd3;

  localparam logic REG_COORDINATE_COUNT = 1'b0;
  localparam logic REG_OCCURRENCE_TOTAL = 1'b1;

  typedef struct packed {
    logic                used;
    logic [KIND_W-1:0]   kind;
    logic [VAL_W-1:0]    value;
    logic [CNT_W-1:0]    count;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } tbl_wr_t;
endpackage

@@ design/index_coordinate_selector_unit.sv @@
// index coordinate selector: each key item is hashed into the key table and probed
// until a free slot or a matching key is found or the probes run out; a wildcard
// skips the probe. the first item of a coordinate starts with a table clearing sweep,
// the last item ends with the scoring states. a new key item is taken only while idle.
// the result strobe is registered after the last coordinate; the receiver cannot stall.
// synchronous active-low reset clears control state and counters, not the table.
module index_coordinate_selector_unit #(
  parameter int MAX_OCCURRENCES = 512,
  parameter int TABLE_DEPTH     = 1024,
  parameter int MAX_COORDINATES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_key_present,
  input  logic [ics_pkg::KIND_W-1:0]     in_key_kind,
  input  logic [31:0]                    in_key_symbol,
  input  logic signed [63:0]             in_key_integer,
  input  logic [31:0]                    in_key_arity,
  output logic                           out_valid,
  output logic [ics_pkg::COORD_W-1:0]    out_chosen_coordinate,
  output logic [ics_pkg::SCORE_W-1:0]    out_chosen_score,
  output logic                           out_admitted,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [ics_pkg::OT_W-1:0]       cfg_data
);
  import ics_pkg::*;
  `include "index_coordinate_selector_unit_defines.svh"

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_DEPTH - 1);
  localparam logic [PW-1:0] LAST_PROBE = PW'(TABLE_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_EXT  = (IW+1)'(TABLE_DEPTH);
  localparam logic [CC_W-1:0] CC_LIM = CC_W'(MAX_COORDINATES);
  localparam logic [OT_W-1:0] OT_LIM = OT_W'(MAX_OCCURRENCES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_PCHK  = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_FIN1  = 3'd5;
  localparam logic [2:0] S_FIN2  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CC_W-1:0]     cc_r;
  logic [OT_W-1:0]     ot_r;
  logic [CC_W-1:0]     coord_r, coord_nxt;
  logic [OT_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]    rigid_r, rigid_nxt;
  logic [PAIR_W-1:0]   pair_r, pair_nxt;
  logic [SCORE_W-1:0]  best_r, best_nxt;
  logic [COORD_W-1:0]  bestc_r, bestc_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [PW-1:0]       probes_r, probes_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                present_r;
  logic [KIND_W-1:0]   kind_r;
  logic [VAL_W-1:0]    value_r;
  logic [CNT_W-1:0]    equal_r, equal_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [SCORE_W-1:0]  score_out_r;
  logic [COORD_W-1:0]  coord_out_r;

  logic                accept;
  logic [VAL_W-1:0]    in_value;
  logic [IW-1:0]       hash_fold;
  logic [IW-1:0]       hash_slot;
  logic [IW-1:0]       slot_adv;
  tbl_wr_t             tbl_wr;
  logic [IW-1:0]       tbl_wr_addr;
  entry_t              rd_data;
  logic                key_match;
  logic [OT_W:0]       occ_inc;
  logic [CC_W:0]       coord_inc;
  logic [PAIR_W:0]     pair_sum;
  logic [PROD_W:0]     score_sum;
  logic [SCORE_W-1:0]  score_sat;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // key value as stored in the table
  always_comb begin
    case (in_key_kind)
      KIND_INTEGER: in_value = in_key_integer;
      KIND_APPLY:   in_value = {in_key_symbol, in_key_arity};
      default:      in_value = {32'd0, in_key_symbol};
    endcase
  end

  // xor fold of kind and value onto the slot index, folded below depth
  always_comb begin
    logic [KIND_W+VAL_W-1:0] w;
    w = {kind_r, value_r};
    hash_fold = '0;
    for (int i = 0; i < KIND_W + VAL_W; i++) begin
      hash_fold[i % IW] = hash_fold[i % IW] ^ w[i];
    end
    if ({1'b0, hash_fold} >= DEPTH_EXT) begin
      hash_slot = IW'({1'b0, hash_fold} - DEPTH_EXT);
    end else begin
      hash_slot = hash_fold;
    end
  end

  assign slot_adv  = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign key_match = (kind_r != KIND_OTHER) && (rd_data.kind == kind_r) &&
                     (rd_data.value == value_r);
  assign occ_inc   = {1'b0, occ_r} + 1'b1;
  assign coord_inc = {1'b0, coord_r} + 1'b1;
  assign pair_sum  = {1'b0, pair_r} +
                     ((rigid_r >= equal_r) ? (PAIR_W+1)'(rigid_r - equal_r) : '0);
  assign score_sum = {1'b0, prod_r} + (PROD_W+1)'(rigid_r);
  assign score_sat = (score_sum > (PROD_W+1)'(SCORE_MAX)) ? SCORE_MAX
                                                          : score_sum[SCORE_W-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    coord_nxt     = coord_r;
    occ_nxt       = occ_r;
    rigid_nxt     = rigid_r;
    pair_nxt      = pair_r;
    best_nxt      = best_r;
    bestc_nxt     = bestc_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    equal_nxt     = equal_r;
    out_valid_nxt = 1'b0;
    tbl_wr        = '0;
    tbl_wr_addr   = slot_r;
    case (state_r)
      S_IDLE: begin
        if (accept && cc_r != '0 && ot_r != '0) begin
          equal_nxt = '0;
          if (occ_r == '0) begin
            rigid_nxt = '0;
            pair_nxt  = '0;
            slot_nxt  = '0;
            if (coord_r == '0) begin
              best_nxt  = '0;
              bestc_nxt = '0;
            end
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = in_key_present ? S_PRD : S_STEP;
          end
        end
      end
      S_CLEAR: begin
        tbl_wr.en = 1'b1;
        tbl_wr.data = '0;
        slot_nxt  = slot_adv;
        if (slot_r == LAST_SLOT) begin
          state_nxt = present_r ? S_PRD : S_STEP;
        end
      end
      S_PRD: begin
        slot_nxt   = hash_slot;
        probes_nxt = '0;
        state_nxt  = S_PCHK;
      end
      S_PCHK: begin
        if (!rd_data.used) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.data.used  = 1'b1;
          tbl_wr.data.kind  = kind_r;
          tbl_wr.data.value = value_r;
          tbl_wr.data.count = CNT_W'(1);
          equal_nxt         = '0;
          state_nxt         = S_STEP;
        end else if (key_match) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.data       = rd_data;
          tbl_wr.data.count = (rd_data.count < COUNT_MAX) ? rd_data.count + 1'b1
                                                          : rd_data.count;
          equal_nxt         = rd_data.count;
          state_nxt         = S_STEP;
        end else if (probes_r == LAST_PROBE) begin
          equal_nxt = '0;
          state_nxt = S_STEP;
        end else begin
          slot_nxt   = slot_adv;
          probes_nxt = probes_r + 1'b1;
        end
      end
      S_STEP: begin
        if (present_r) begin
          pair_nxt  = pair_sum[PAIR_W] ? PAIR_MAX : pair_sum[PAIR_W-1:0];
          rigid_nxt = (rigid_r < COUNT_MAX) ? rigid_r + 1'b1 : rigid_r;
        end
        if (occ_inc < {1'b0, ot_r}) begin
          occ_nxt   = occ_inc[OT_W-1:0];
          state_nxt = S_IDLE;
        end else begin
          occ_nxt   = '0;
          state_nxt = S_FIN1;
        end
      end
      S_FIN1: begin
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (score_sat > best_r) begin
          best_nxt  = score_sat;
          bestc_nxt = coord_r[COORD_W-1:0];
        end
        if (coord_inc < {1'b0, cc_r}) begin
          coord_nxt = coord_inc[CC_W-1:0];
        end else begin
          coord_nxt     = '0;
          out_valid_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cc_r        <= '0;
      ot_r        <= '0;
      coord_r     <= '0;
      occ_r       <= '0;
      rigid_r     <= '0;
      pair_r      <= '0;
      best_r      <= '0;
      bestc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coord_r     <= coord_nxt;
      occ_r       <= occ_nxt;
      rigid_r     <= rigid_nxt;
      pair_r      <= pair_nxt;
      best_r      <= best_nxt;
      bestc_r     <= bestc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COORDINATE_COUNT) begin
          cc_r <= ({23'd0, cfg_data[CC_W-1:0]} > MAX_COORDINATES) ? CC_LIM
                                                                  : cfg_data[CC_W-1:0];
        end else begin
          ot_r <= ({22'd0, cfg_data} > MAX_OCCURRENCES) ? OT_LIM : cfg_data;
        end
      end
    end
  end

  // request payload, probe state and score datapath
  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    probes_r <= probes_nxt;
    equal_r  <= equal_nxt;
    prod_r   <= pair_r * ({1'b0, ot_r} + 1'b1);
    if (accept) begin
      present_r <= in_key_present;
      kind_r    <= in_key_kind;
      value_r   <= in_value;
    end
    if (out_valid_nxt) begin
      score_out_r <= best_nxt;
      coord_out_r <= bestc_nxt;
    end
  end

  ics_table #(
    .DEPTH(TABLE_DEPTH),
    .IW   (IW)
  ) u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .wr_addr(tbl_wr_addr),
    .rd_addr(slot_nxt),
    .rd_data(rd_data)
  );

  assign out_valid             = out_valid_r;
  assign out_chosen_coordinate = coord_out_r;
  assign out_chosen_score      = score_out_r;
  assign out_admitted          = (score_out_r != '0);

  // checks
  `ICS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `ICS_ASSERT_NEXT(a_take_busy, accept && cc_r != '0 && ot_r != '0, busy)
  `ICS_ASSERT(a_probe_bound, (state_r == S_PCHK) |-> (probes_r <= LAST_PROBE))
  `ICS_ASSERT(a_strobe_idle, out_valid |-> !busy)
  `ICS_ASSERT(a_counters_bound, (occ_r <= ot_r || !busy) && coord_r <= cc_r || !busy)
endmodule

@@ design/ics_table.sv @@
// key count table: one write port, one registered read port
// depends on ics_pkg
module ics_table #(
  parameter int DEPTH = 1024,
  parameter int IW    = 10
) (
  input  logic             clk,
  input  ics_pkg::tbl_wr_t wr,
  input  logic [IW-1:0]    wr_addr,
  input  logic [IW-1:0]    rd_addr,
  output ics_pkg::entry_t  rd_data
);
  import ics_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule
